// ----- src/mi3_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse and determinant block.
package mi3_pkg;

  // Element format, Q16.16
  localparam int EW = 32;
  localparam int FB = 16;

  // Exact cofactor (65 bits) and exact determinant (99 bits)
  localparam int CW = 2 * EW + 1;
  localparam int DW = 3 * EW + 3;

  // Divider: one quotient bit per step, two steps per pipeline stage
  localparam int SPS = 2;
  localparam int DIV_STAGES = EW / SPS;

  // Cycles from an accepted request to its done strobe
  localparam int LAT_COF = 2;
  localparam int LAT_DET = 4;
  localparam int LAT_DIV = DIV_STAGES + 3;
  localparam int LATENCY = LAT_COF + LAT_DET + LAT_DIV;

  localparam logic [EW-1:0] ONE = EW'(1) << FB;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;

  // Rounded determinant as the divider needs it
  typedef struct packed {
    logic [EW-1:0] dmag;
    logic          dneg;
    logic          singular;
    logic [EW-1:0] dout;
  } det_info_t;

endpackage

// ----- src/mi3_cof.sv -----
// Products and exact adjugate cofactors, two register stages.
module mi3_cof (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  mi3_pkg::elem_t   m [9],
  output logic             out_valid,
  output mi3_pkg::cof_t    cof [9],
  output mi3_pkg::elem_t   row0 [3]
);

  logic signed [2*mi3_pkg::EW-1:0] pt [9];
  logic signed [2*mi3_pkg::EW-1:0] pu [9];
  mi3_pkg::elem_t                  row0_a [3];
  logic                            valid_a;

  // Stage A: the two products of each 2x2 minor
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R1 = (j + 1) % 3;
      localparam int R2 = (j + 2) % 3;
      localparam int C1 = (i + 1) % 3;
      localparam int C2 = (i + 2) % 3;
      always_ff @(posedge clk) begin
        pt[i*3+j] <= (2*mi3_pkg::EW)'(m[R1*3+C1]) * (2*mi3_pkg::EW)'(m[R2*3+C2]);
        pu[i*3+j] <= (2*mi3_pkg::EW)'(m[R1*3+C2]) * (2*mi3_pkg::EW)'(m[R2*3+C1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      row0_a[j] <= m[j];
    end
  end

  // Stage B: cofactor difference, full width
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      cof[k] <= mi3_pkg::CW'(pt[k]) - mi3_pkg::CW'(pu[k]);
    end
    for (int j = 0; j < 3; j++) begin
      row0[j] <= row0_a[j];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

endmodule

// ----- src/mi3_det.sv -----
// Determinant expansion, rounding and saturation, four register stages.
module mi3_det (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mi3_pkg::cof_t       cof [9],
  input  mi3_pkg::elem_t      row0 [3],
  output logic                out_valid,
  output mi3_pkg::det_info_t  info,
  output mi3_pkg::cof_t       cof_out [9]
);

  localparam int QW = mi3_pkg::DW - 2 * mi3_pkg::FB + 1;

  logic signed [mi3_pkg::CW-1:0] plo [3];
  logic signed [mi3_pkg::CW-1:0] phi [3];
  logic signed [mi3_pkg::DW-1:0] det_d;
  logic [mi3_pkg::DW-1:0]        mag_e;
  logic                          neg_e;
  logic [3:0]                    valid_p;
  mi3_pkg::cof_t                 cof_d [4][9];
  logic [QW-1:0]                 q_f;
  logic [mi3_pkg::EW-1:0]        lim_f;
  logic [mi3_pkg::EW-1:0]        dmag_f;

  // Stage C: row 0 element times cofactor, split at the low 32 bits
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      plo[j] <= mi3_pkg::CW'(row0[j]) *
                mi3_pkg::CW'($signed({1'b0, cof[j*3][mi3_pkg::EW-1:0]}));
      phi[j] <= mi3_pkg::CW'(row0[j]) *
                mi3_pkg::CW'($signed(cof[j*3][mi3_pkg::CW-1:mi3_pkg::EW]));
    end
  end

  // Stage D: exact determinant
  always_ff @(posedge clk) begin
    det_d <= (mi3_pkg::DW'(phi[0]) <<< mi3_pkg::EW) + mi3_pkg::DW'(plo[0])
           + (mi3_pkg::DW'(phi[1]) <<< mi3_pkg::EW) + mi3_pkg::DW'(plo[1])
           + (mi3_pkg::DW'(phi[2]) <<< mi3_pkg::EW) + mi3_pkg::DW'(plo[2]);
  end

  // Stage E: sign and magnitude
  always_ff @(posedge clk) begin
    neg_e <= det_d[mi3_pkg::DW-1];
    mag_e <= det_d[mi3_pkg::DW-1] ? mi3_pkg::DW'(-det_d) : mi3_pkg::DW'(det_d);
  end

  // Stage F: drop the fraction with half-away rounding, then clamp
  always_comb begin
    q_f = QW'(mag_e[mi3_pkg::DW-1:2*mi3_pkg::FB]) + QW'(mag_e[2*mi3_pkg::FB-1]);
    lim_f = neg_e ? (mi3_pkg::EW'(1) << (mi3_pkg::EW - 1))
                  : ((mi3_pkg::EW'(1) << (mi3_pkg::EW - 1)) - mi3_pkg::EW'(1));
    dmag_f = (q_f > QW'(lim_f)) ? lim_f : q_f[mi3_pkg::EW-1:0];
  end

  always_ff @(posedge clk) begin
    info.dmag     <= dmag_f;
    info.dneg     <= neg_e;
    info.singular <= (dmag_f == '0);
    info.dout     <= neg_e ? mi3_pkg::EW'(-dmag_f) : dmag_f;
  end

  // Cofactors travel alongside
  always_ff @(posedge clk) begin
    cof_d[0] <= cof;
    for (int s = 1; s < 4; s++) begin
      cof_d[s] <= cof_d[s-1];
    end
  end
  assign cof_out = cof_d[3];

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= '0;
    end else begin
      valid_p <= {valid_p[2:0], in_valid};
    end
  end
  assign out_valid = valid_p[3];

endmodule

// ----- src/mi3_div.sv -----
// Nine-lane pipelined restoring divider, rounding, saturation and output select.
module mi3_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mi3_pkg::det_info_t  info,
  input  mi3_pkg::cof_t       cof [9],
  output logic                out_valid,
  output mi3_pkg::elem_t      inv [9],
  output mi3_pkg::elem_t      det,
  output logic                singular
);

  localparam int EW = mi3_pkg::EW;
  localparam int NS = mi3_pkg::DIV_STAGES;

  // Entry stage: magnitude and quotient sign
  logic [mi3_pkg::CW-1:0] mag_g [9];
  logic                   sgn_g [9];
  mi3_pkg::det_info_t     info_g;
  logic                   valid_g;

  // Divider stages
  logic [EW:0]            rem_p [NS+1][9];
  logic [EW-1:0]          lo_p  [NS+1][9];
  logic [EW-1:0]          q_p   [NS+1][9];
  logic                   ovf_p [NS+1][9];
  logic                   sgn_p [NS+1][9];
  mi3_pkg::det_info_t     info_p [NS+1];
  logic [NS:0]            valid_p;

  logic [EW:0]            rem_n [NS][9];
  logic [EW-1:0]          lo_n  [NS][9];
  logic [EW-1:0]          q_n   [NS][9];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      mag_g[k] <= cof[k][mi3_pkg::CW-1] ? mi3_pkg::CW'(-cof[k]) : mi3_pkg::CW'(cof[k]);
      sgn_g[k] <= cof[k][mi3_pkg::CW-1] ^ info.dneg;
    end
    info_g <= info;
  end

  // Two shift-subtract steps per stage
  always_comb begin
    logic [EW:0]   r;
    logic [EW-1:0] l;
    logic [EW-1:0] qq;
    logic          qb;
    for (int s = 0; s < NS; s++) begin
      for (int k = 0; k < 9; k++) begin
        r  = rem_p[s][k];
        l  = lo_p[s][k];
        qq = q_p[s][k];
        for (int t = 0; t < mi3_pkg::SPS; t++) begin
          r  = {r[EW-1:0], l[EW-1]};
          l  = {l[EW-2:0], 1'b0};
          qb = (r >= {1'b0, info_p[s].dmag});
          if (qb) begin
            r = r - {1'b0, info_p[s].dmag};
          end
          qq = {qq[EW-2:0], qb};
        end
        rem_n[s][k] = r;
        lo_n[s][k]  = l;
        q_n[s][k]   = qq;
      end
    end
  end

  // Quotient of 2^32 or more saturates; otherwise the high part seeds the remainder.
  // The divider stages follow in the same block.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      rem_p[0][k] <= mag_g[k][mi3_pkg::CW-1:EW];
      ovf_p[0][k] <= (mag_g[k][mi3_pkg::CW-1:EW] >= {1'b0, info_g.dmag});
      lo_p[0][k]  <= mag_g[k][EW-1:0];
      q_p[0][k]   <= '0;
      sgn_p[0][k] <= sgn_g[k];
    end
    info_p[0] <= info_g;
    for (int s = 0; s < NS; s++) begin
      for (int k = 0; k < 9; k++) begin
        rem_p[s+1][k] <= rem_n[s][k];
        lo_p[s+1][k]  <= lo_n[s][k];
        q_p[s+1][k]   <= q_n[s][k];
        ovf_p[s+1][k] <= ovf_p[s][k];
        sgn_p[s+1][k] <= sgn_p[s][k];
      end
      info_p[s+1] <= info_p[s];
    end
  end

  // Final stage: round half away, saturate, identity on a singular matrix
  always_ff @(posedge clk) begin
    logic [EW:0]   d;
    logic [EW:0]   q33;
    logic [EW-1:0] sat;
    for (int k = 0; k < 9; k++) begin
      d   = {1'b0, info_p[NS].dmag};
      q33 = {1'b0, q_p[NS][k]} + (EW+1)'(rem_p[NS][k] >= (d - rem_p[NS][k]));
      if (!sgn_p[NS][k]) begin
        if (ovf_p[NS][k] || q33 > (EW+1)'((EW'(1) << (EW - 1)) - EW'(1))) begin
          sat = (EW'(1) << (EW - 1)) - EW'(1);
        end else begin
          sat = q33[EW-1:0];
        end
      end else begin
        if (ovf_p[NS][k] || q33 > (EW+1)'(EW'(1) << (EW - 1))) begin
          sat = EW'(1) << (EW - 1);
        end else begin
          sat = EW'(-q33[EW-1:0]);
        end
      end
      if (info_p[NS].singular) begin
        inv[k] <= (k % 4 == 0) ? mi3_pkg::ONE : '0;
      end else begin
        inv[k] <= sat;
      end
    end
    det      <= info_p[NS].dout;
    singular <= info_p[NS].singular;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_g   <= 1'b0;
      valid_p   <= '0;
      out_valid <= 1'b0;
    end else begin
      valid_g   <= in_valid;
      valid_p   <= {valid_p[NS-1:0], valid_g};
      out_valid <= valid_p[NS];
    end
  end

endmodule

// ----- src/matrix3_inverse_determinant.sv -----
// Top level: 3x3 matrix inverse and determinant, Q16.16, fully pipelined.
//
//  channel   signals                           direction  handshake
//  request   start, busy, m_r0c0 .. m_r2c2     in         start && !busy
//  result    done, inv_r0c0 .. inv_r2c2,       out        done, one cycle
//            determinant, singular
//
// One request per cycle; each result passes the cofactor and determinant stages
// and then the 32-step divider (two quotient bits per stage) before it appears.
// Reset (rst, synchronous) clears all valid bits; busy is high only in reset.
// Nothing stalls: results leave on done and are never held.
module matrix3_inverse_determinant (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] m_r0c0,
  input  logic [31:0] m_r0c1,
  input  logic [31:0] m_r0c2,
  input  logic [31:0] m_r1c0,
  input  logic [31:0] m_r1c1,
  input  logic [31:0] m_r1c2,
  input  logic [31:0] m_r2c0,
  input  logic [31:0] m_r2c1,
  input  logic [31:0] m_r2c2,
  output logic        done,
  output logic [31:0] inv_r0c0,
  output logic [31:0] inv_r0c1,
  output logic [31:0] inv_r0c2,
  output logic [31:0] inv_r1c0,
  output logic [31:0] inv_r1c1,
  output logic [31:0] inv_r1c2,
  output logic [31:0] inv_r2c0,
  output logic [31:0] inv_r2c1,
  output logic [31:0] inv_r2c2,
  output logic [31:0] determinant,
  output logic        singular
);

  mi3_pkg::elem_t     m [9];
  mi3_pkg::cof_t      cof_b [9];
  mi3_pkg::elem_t     row0_b [3];
  logic               valid_b;
  mi3_pkg::cof_t      cof_f [9];
  mi3_pkg::det_info_t info_f;
  logic               valid_f;
  mi3_pkg::elem_t     inv [9];
  mi3_pkg::elem_t     det;
  logic               accept;

  assign busy   = rst;
  assign accept = start && !busy;

  assign m[0] = m_r0c0;
  assign m[1] = m_r0c1;
  assign m[2] = m_r0c2;
  assign m[3] = m_r1c0;
  assign m[4] = m_r1c1;
  assign m[5] = m_r1c2;
  assign m[6] = m_r2c0;
  assign m[7] = m_r2c1;
  assign m[8] = m_r2c2;

  mi3_cof u_cof (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .m         (m),
    .out_valid (valid_b),
    .cof       (cof_b),
    .row0      (row0_b)
  );

  mi3_det u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_b),
    .cof       (cof_b),
    .row0      (row0_b),
    .out_valid (valid_f),
    .info      (info_f),
    .cof_out   (cof_f)
  );

  mi3_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_f),
    .info      (info_f),
    .cof       (cof_f),
    .out_valid (done),
    .inv       (inv),
    .det       (det),
    .singular  (singular)
  );

  assign inv_r0c0    = inv[0];
  assign inv_r0c1    = inv[1];
  assign inv_r0c2    = inv[2];
  assign inv_r1c0    = inv[3];
  assign inv_r1c1    = inv[4];
  assign inv_r1c2    = inv[5];
  assign inv_r2c0    = inv[6];
  assign inv_r2c1    = inv[7];
  assign inv_r2c2    = inv[8];
  assign determinant = det;

`ifndef SYNTH
  // Each result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, mi3_pkg::LATENCY))
    else $error("result without matching request");

  // Singular flag agrees with a zero determinant
  a_sing_det: assert property (@(posedge clk) disable iff (rst)
    done |-> (singular == (determinant == '0)))
    else $error("singular flag and determinant disagree");

  // Singular results carry the identity
  a_sing_id: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (inv_r0c0 == mi3_pkg::ONE && inv_r1c1 == mi3_pkg::ONE &&
                            inv_r2c2 == mi3_pkg::ONE && inv_r0c1 == '0 && inv_r1c0 == '0))
    else $error("singular result is not the identity");
`endif

endmodule

// ----- tb/matrix3_inverse_determinant_tb.sv -----
// Testbench for the 3x3 matrix inverse and determinant block: directed and random matrices.
`timescale 1ns / 1ps

module matrix3_inverse_determinant_tb;

  localparam int EW = mi3_pkg::EW;
  localparam int GAP_MAX = 12;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [127:0] HALF = 128'(1) << (EW - 1);
  localparam logic [127:0] EMASK = (128'(1) << EW) - 1;

  typedef struct {
    logic [EW-1:0] inv [9];
    logic [EW-1:0] det;
    logic          singular;
  } inverse_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [EW-1:0] m [9];
  logic done;
  logic [EW-1:0] inv [9];
  logic [EW-1:0] determinant;
  logic singular;

  inverse_t pending_inverses[$];
  int  errors = 0;
  longint cycles = 0;
  bit  dense = 0;

  always #1 clk = ~clk;

  matrix3_inverse_determinant dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m_r0c0(m[0]), .m_r0c1(m[1]), .m_r0c2(m[2]),
    .m_r1c0(m[3]), .m_r1c1(m[4]), .m_r1c2(m[5]),
    .m_r2c0(m[6]), .m_r2c1(m[7]), .m_r2c2(m[8]),
    .done(done),
    .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
    .inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
    .inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
    .determinant(determinant), .singular(singular)
  );

  // Clamp a sign and magnitude to the element range
  function automatic logic [EW-1:0] clamp_elem(bit neg, logic [127:0] mag);
    logic [127:0] r;
    if (!neg) begin
      r = (mag > HALF - 1) ? HALF - 1 : mag;
    end else begin
      r = (mag > HALF) ? HALF : mag;
      r = (128'(0) - r) & EMASK;
    end
    return r[EW-1:0];
  endfunction

  // Exact adjugate, rounded determinant, rounded quotients
  function automatic inverse_t invert_matrix(logic [EW-1:0] a [9]);
    inverse_t res;
    logic signed [127:0] e [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] d;
    logic [127:0] mag, dmag, q, rem;
    bit dneg, cneg;
    int r1, r2, c1, c2;
    for (int k = 0; k < 9; k++) e[k] = 128'(signed'(a[k]));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = (j + 1) % 3; r2 = (j + 2) % 3;
        c1 = (i + 1) % 3; c2 = (i + 2) % 3;
        cof[i*3+j] = e[r1*3+c1] * e[r2*3+c2] - e[r1*3+c2] * e[r2*3+c1];
      end
    end
    d = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    dneg = d < 0;
    mag = dneg ? -d : d;
    dmag = (mag >> (2 * mi3_pkg::FB)) + mag[2*mi3_pkg::FB-1];
    res.det = clamp_elem(dneg, dmag);
    if (dneg && dmag > HALF) dmag = HALF;
    if (!dneg && dmag > HALF - 1) dmag = HALF - 1;
    if (dmag == 0) begin
      for (int k = 0; k < 9; k++) res.inv[k] = (k % 4 == 0) ? mi3_pkg::ONE : '0;
      res.det = '0;
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      cneg = cof[k] < 0;
      mag = cneg ? -cof[k] : cof[k];
      q = mag / dmag;
      rem = mag % dmag;
      if (rem >= dmag - rem) q++;
      res.inv[k] = clamp_elem(cneg != dneg, q);
    end
    res.singular = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [EW-1:0] got, logic [EW-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Send one request; the gap before it is random unless in a dense stretch
  task automatic send_matrix(logic [EW-1:0] a [9]);
    int gap;
    gap = dense ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    for (int k = 0; k < 9; k++) m[k] <= a[k];
    do @(posedge clk); while (busy);
    pending_inverses.push_back(invert_matrix(a));
  endtask

  task automatic send_diag(int unsigned x, int unsigned y, int unsigned z);
    logic [EW-1:0] a [9];
    for (int k = 0; k < 9; k++) a[k] = '0;
    a[0] = x; a[4] = y; a[8] = z;
    send_matrix(a);
  endtask

  task automatic test_directed();
    logic [EW-1:0] a [9];
    send_diag(0, 0, 0);                         // zero matrix, singular
    send_diag(mi3_pkg::ONE, mi3_pkg::ONE, mi3_pkg::ONE); // identity
    send_diag(mi3_pkg::ONE, mi3_pkg::ONE, 32'h100);      // small determinant
    send_diag(2, 1, 32'h4000_0000);             // determinant exactly half an LSB
    send_diag(32'hFFFF_FFFE, 1, 32'h4000_0000); // same, negative
    send_diag(1, 1, 1);                         // rounds to zero, singular
    send_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // determinant overflow
    send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000); // negative overflow
    send_diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_diag(mi3_pkg::ONE << 1, 32'hFFFF_0000, mi3_pkg::ONE >> 1);
    for (int k = 0; k < 9; k++) a[k] = 32'h7FFF_FFFF;
    send_matrix(a);                             // all max, singular
    for (int k = 0; k < 9; k++) a[k] = 32'h8000_0000;
    send_matrix(a);
    for (int k = 0; k < 9; k++) a[k] = 32'hFFFF_FFFF;
    send_matrix(a);
    for (int k = 0; k < 9; k++) a[k] = '0;
    a[1] = mi3_pkg::ONE; a[3] = mi3_pkg::ONE; a[8] = mi3_pkg::ONE; // row swap permutation
    send_matrix(a);
    for (int k = 0; k < 9; k++) a[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_matrix(a);
    for (int k = 0; k < 9; k++) a[k] = (k % 4 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    send_matrix(a);
  endtask

  task automatic test_random(int count);
    logic [EW-1:0] a [9];
    int kind;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) dense = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) begin
        case (kind)
          0, 1, 2: a[k] = $urandom;                              // full range
          3, 4, 5, 6: a[k] = $urandom_range(0, 32'h8_0000) - 32'h4_0000; // within +-4.0
          7: a[k] = $urandom_range(0, 32'h200) - 32'h100;        // tiny values
          default: a[k] = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
        endcase
      end
      // some matrices made singular by a repeated row
      if (kind == 8) for (int c = 0; c < 3; c++) a[6 + c] = a[c];
      send_matrix(a);
    end
    dense = 0;
  endtask

  // Check each result against the oldest pending expectation
  always @(posedge clk) begin
    inverse_t want;
    if (!rst && done) begin
      if (pending_inverses.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        want = pending_inverses.pop_front();
        for (int k = 0; k < 9; k++)
          if (inv[k] !== want.inv[k]) report_mismatch($sformatf("inv[%0d]", k), inv[k], want.inv[k]);
        if (determinant !== want.det) report_mismatch("determinant", determinant, want.det);
        if (singular !== want.singular)
          report_mismatch("singular", EW'(singular), EW'(want.singular));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    for (int k = 0; k < 9; k++) m[k] <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(2000);
    start <= 1'b0;
    @(posedge clk);
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (mi3_pkg::LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
